>>> rtl/core/sxr_pkg.sv
`default_nettype none

package sxr_pkg;

	localparam int Width   = 32;
	localparam int QDepth  = 2;
	localparam int QPtrW   = $clog2(QDepth);
	localparam int QCntW   = $clog2(QDepth + 1);
	localparam int DivCntW = $clog2(Width);

	// One classified request, as it travels from the front end to the back end.
	typedef struct packed {
		logic [Width-1:0] lo;     // lower bound after ordering
		logic [Width-1:0] span;   // hi - lo + 1, wrapped to 32 bits
		logic             equal;  // both bounds equal: no draw
		logic             full;   // span wrapped to zero
	} sxr_item_t;

endpackage

`default_nettype wire

>>> rtl/core/sxr_front.sv
`default_nettype none

module sxr_front import sxr_pkg::*; (
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [Width-1:0] bound_a,
	input  wire logic [Width-1:0] bound_b,
	input  wire logic             q_full,
	output logic                  q_push,
	output sxr_item_t             q_item
);

	logic             swap;
	logic [Width-1:0] lo;
	logic [Width-1:0] hi;
	logic [Width-1:0] span;

	// Order the bounds as signed values.
	assign swap = $signed(bound_a) > $signed(bound_b);
	assign lo   = swap ? bound_b : bound_a;
	assign hi   = swap ? bound_a : bound_b;
	assign span = hi - lo + Width'(1);

	assign q_item = '{
		lo:    lo,
		span:  span,
		equal: (bound_a == bound_b),
		full:  (bound_a != bound_b) && (span == '0)
	};

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

endmodule

`default_nettype wire

>>> rtl/core/sxr_queue.sv
`default_nettype none

module sxr_queue import sxr_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire sxr_item_t push_item,
	output logic           full,
	input  wire logic      pop,
	output logic           valid,
	output sxr_item_t      pop_item
);

	sxr_item_t        mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	assign full     = (cnt_q == QCntW'(QDepth));
	assign valid    = (cnt_q != '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
			end
			cnt_q <= cnt_q + QCntW'(push) - QCntW'(pop);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/sxr_back.sv
`default_nettype none

module sxr_back import sxr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             seed_we,
	input  wire logic [Width-1:0] seed_value,
	input  wire logic             q_valid,
	input  wire sxr_item_t        q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [Width-1:0]      random_value,
	output logic                  span_overflow
);

	typedef enum logic [2:0] {ST_IDLE, ST_MIX, ST_FOLD, ST_DIV, ST_DONE} st_t;

	st_t                st_q;
	logic [Width-1:0]   gen_state_q;
	logic [Width-1:0]   lo_q;
	logic [Width-1:0]   span_q;
	logic               full_q;
	logic [Width-1:0]   pre_q;
	logic [Width-1:0]   k2_q;
	logic [Width-1:0]   k4_q;
	logic [Width-1:0]   sel_q;
	logic [Width-1:0]   rem_q;
	logic [Width-1:0]   dvd_q;
	logic [DivCntW-1:0] cnt_q;
	logic               out_valid_q;
	logic [Width-1:0]   value_q;
	logic               ovf_q;

	logic [Width-1:0] t1, t2, t3, k0, k1, k2, k3, k4;
	logic [3:0]       amt;
	logic [Width-1:0] fold;
	logic [Width:0]   trial;
	logic [Width:0]   trial_sub;
	logic [Width-1:0] rem_next;

	// Residue mod 15 by nibble sums, since 16 is 1 mod 15.
	function automatic logic [3:0] mod15(input logic [Width-1:0] v);
		logic [6:0] acc;
		logic [4:0] red;
		acc = '0;
		for (int i = 0; i < Width / 4; i++) begin
			acc = acc + 7'(v[4*i +: 4]);
		end
		red = 5'(acc[6:4]) + 5'(acc[3:0]);
		if (red >= 5'd15) begin
			red = red - 5'd15;
		end
		return red[3:0];
	endfunction

	// First half of the mixing network.
	always_comb begin
		t1 = (gen_state_q << 20) ^ (gen_state_q >> 7);
		t2 = Width'($signed(t1) >>> 13) ^ (gen_state_q << 6) ^ t1;
		t3 = t1 ^ Width'($signed(t2) >>> 10) ^ (gen_state_q << 6);
		k0 = Width'($signed(t3) >>> 12) ^ (t2 << 2);
		k1 = (t3 << 18) ^ t1;
		k2 = t1 ^ t2 ^ t3;
		k3 = ((gen_state_q ^ t1) << 24) ^ t3;
		k4 = k3 ^ (t2 << 12);
	end

	// Second half: variable shift, then fold.
	always_comb begin
		amt  = mod15(sel_q);
		fold = ((pre_q ^ (k4_q << amt)) >> 3) ^ k2_q ^ k4_q;
	end

	// One restoring step of the remainder.
	assign trial     = {rem_q, dvd_q[Width-1]};
	assign trial_sub = trial - {1'b0, span_q};
	assign rem_next  = (trial >= {1'b0, span_q}) ? trial_sub[Width-1:0] : trial[Width-1:0];

	assign q_pop         = (st_q == ST_IDLE) && q_valid;
	assign out_valid     = out_valid_q;
	assign random_value  = value_q;
	assign span_overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			gen_state_q <= '0;
			lo_q        <= '0;
			span_q      <= '0;
			full_q      <= 1'b0;
			pre_q       <= '0;
			k2_q        <= '0;
			k4_q        <= '0;
			sel_q       <= '0;
			rem_q       <= '0;
			dvd_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			value_q     <= '0;
			ovf_q       <= 1'b0;
		end else begin
			// Drop the beat once taken, unless a new one loads in the same cycle.
			if (out_valid_q && out_ready && (st_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						lo_q   <= q_item.lo;
						span_q <= q_item.span;
						full_q <= q_item.full;
						if (q_item.equal) begin
							rem_q <= '0;
							st_q  <= ST_DONE;
						end else begin
							st_q <= ST_MIX;
						end
					end
				end
				ST_MIX: begin
					pre_q <= k0 ^ (k1 << 13) ^ (k2 >> 5) ^ k3;
					k2_q  <= k2;
					k4_q  <= k4;
					sel_q <= k2 ^ k1;
					st_q  <= ST_FOLD;
				end
				ST_FOLD: begin
					if (full_q) begin
						rem_q <= fold;
						st_q  <= ST_DONE;
					end else begin
						dvd_q <= fold;
						rem_q <= '0;
						cnt_q <= '0;
						st_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q + DivCntW'(1);
					if (cnt_q == DivCntW'(Width - 1)) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						value_q     <= rem_q + lo_q;
						ovf_q       <= full_q;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			// Seed load: the user writes it only while idle, the block does not enforce it; otherwise advance on the fold cycle.
			if (seed_we) begin
				gen_state_q <= (seed_value == '0) ? Width'(1) : seed_value;
			end else if (st_q == ST_FOLD) begin
				gen_state_q <= fold;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/shift_xor_range_random_unit.sv
// Sequence: pop from the queue, mixing in ST_MIX and ST_FOLD, 32 remainder steps one
//   bit each in ST_DIV, then ST_DONE loads the output once it is free; equal bounds go
//   from the pop to ST_DONE, and a full 32-bit span skips the remainder steps.
// Occupancy: the back end works on one request at a time and pops the next only in
//   ST_IDLE, paced by the bit-serial remainder unit; a 2-deep queue buffers the front.
// Reset: arst_n clears the generator state to zero, empties the queue and drops out_valid.
`default_nettype none

module shift_xor_range_random_unit import sxr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// seed register write
	input  wire logic             seed_we,
	input  wire logic [Width-1:0] seed_value,
	// request channel
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [Width-1:0] bound_a,
	input  wire logic [Width-1:0] bound_b,
	// result channel
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [Width-1:0]      random_value,
	output logic                  span_overflow
);

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_valid;
	sxr_item_t push_item;
	sxr_item_t pop_item;

	// Front end: order the bounds, compute the span and flag the
	// special cases (equal bounds, full 32-bit span). One beat per cycle
	// while the queue has room.
	sxr_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.bound_a  (bound_a),
		.bound_b  (bound_b),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	// Decouple the front from the multi-cycle back end.
	sxr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	// Back end: for unequal bounds, advance the generator state in ST_MIX
	// and ST_FOLD and reduce it modulo the span one bit per cycle unless the
	// span is full; add the low bound, held in the output register until the beat is taken.
	sxr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.seed_we       (seed_we),
		.seed_value    (seed_value),
		.q_valid       (q_valid),
		.q_item        (pop_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.random_value  (random_value),
		.span_overflow (span_overflow)
	);

endmodule

`default_nettype wire

>>> rtl/core/sxr_checker.sv
`default_nettype none

module sxr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] random_value,
	input wire logic        span_overflow
);

	// Queue of two, one in the back end, one in the output register.
	localparam logic [2:0] MaxPending = 3'd4;

	logic [2:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(random_value)
			&& $stable(span_overflow))
		else $error("result beat changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result beat without an accepted request");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= MaxPending)
		else $error("more requests in flight than the unit can hold");

	a_full_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> pending_q >= 3'd2)
		else $error("request port stalled with the queue not full");

endmodule

bind shift_xor_range_random_unit sxr_checker u_sxr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.random_value  (random_value),
	.span_overflow (span_overflow)
);

`default_nettype wire
